FILE: hdl/lad_pkg.sv
// ----------------------------------------------------------------------------
// lad_pkg
// Shared constants and types for the linear array deque.
// ----------------------------------------------------------------------------
package lad_pkg;

  localparam int DefaultDepth = 8;

  localparam int DataW     = 32;
  localparam int OpW       = 2;
  localparam int StatW     = 2;
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 40;

  localparam logic [OpW-1:0] OP_INS_REAR  = 2'd0;
  localparam logic [OpW-1:0] OP_DEL_FRONT = 2'd1;
  localparam logic [OpW-1:0] OP_INS_FRONT = 2'd2;
  localparam logic [OpW-1:0] OP_DEL_REAR  = 2'd3;

  localparam logic [StatW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatW-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [StatW-1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } lad_cmd_t;

endpackage

FILE: hdl/lad_ctrl.sv
// ----------------------------------------------------------------------------
// lad_ctrl
// Sequencer for the deque: accepts one item, steps it through the datapath
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module lad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lad_pkg::lad_cmd_t cmd_o
);
  import lad_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_FETCH = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC:  state_d = S_FETCH;
      S_FETCH: state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.load    = (state_q == S_FETCH);

endmodule

FILE: hdl/lad_dpath.sv
// ----------------------------------------------------------------------------
// lad_dpath
// Deque datapath: slot memory, front and rear indices, empty flag and the
// result register.
// ----------------------------------------------------------------------------
module lad_dpath #(
  parameter int DEPTH = lad_pkg::DefaultDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lad_pkg::lad_cmd_t                   cmd_i,
  input  logic [lad_pkg::OpW-1:0]             op_i,
  input  logic signed [lad_pkg::DataW-1:0]    data_in_i,
  output logic signed [lad_pkg::DataW-1:0]    data_out_o,
  output logic [lad_pkg::StatW-1:0]           status_o
);
  import lad_pkg::*;

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IdxW-1:0] TopIdx = IdxW'(DEPTH - 1);

  logic signed [DataW-1:0] mem [DEPTH];

  logic [OpW-1:0]          op_q;
  logic signed [DataW-1:0] din_q;
  logic [IdxW-1:0]         front_q, front_d;
  logic [IdxW-1:0]         rear_q, rear_d;
  logic                    empty_q, empty_d;
  logic [StatW-1:0]        stat_q, stat_d;
  logic                    del_ok_q, del_ok_d;
  logic signed [DataW-1:0] rd_q;
  logic signed [DataW-1:0] dout_q;
  logic                    we;
  logic [IdxW-1:0]         waddr;
  logic [IdxW-1:0]         raddr;

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    empty_d  = empty_q;
    stat_d   = STAT_OK;
    del_ok_d = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    raddr    = front_q;
    case (op_q)
      OP_INS_REAR: begin
        if (empty_q) begin
          we      = 1'b1;
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
        end else if (rear_q == TopIdx) begin
          stat_d = STAT_OVERFLOW;
        end else begin
          rear_d = rear_q + 1'b1;
          waddr  = rear_q + 1'b1;
          we     = 1'b1;
        end
      end
      OP_DEL_FRONT: begin
        raddr = front_q;
        if (empty_q) begin
          stat_d = STAT_UNDERFLOW;
        end else begin
          del_ok_d = 1'b1;
          if (front_q == rear_q) begin
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b1;
          end else begin
            front_d = front_q + 1'b1;
          end
        end
      end
      OP_INS_FRONT: begin
        if (empty_q) begin
          we      = 1'b1;
          front_d = '0;
          rear_d  = '0;
          empty_d = 1'b0;
        end else if (front_q == '0) begin
          stat_d = STAT_OVERFLOW;
        end else begin
          front_d = front_q - 1'b1;
          waddr   = front_q - 1'b1;
          we      = 1'b1;
        end
      end
      default: begin
        raddr = rear_q;
        if (empty_q) begin
          stat_d = STAT_UNDERFLOW;
        end else begin
          del_ok_d = 1'b1;
          if (front_q == rear_q) begin
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b1;
          end else begin
            rear_d = rear_q - 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) mem[waddr] <= din_q;
    if (cmd_i.exec) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      din_q <= data_in_i;
    end
    if (cmd_i.exec) begin
      stat_q   <= stat_d;
      del_ok_q <= del_ok_d;
    end
    if (cmd_i.load) dout_q <= del_ok_q ? rd_q : '0;
  end

  assign data_out_o = dout_q;
  assign status_o   = stat_q;

endmodule

FILE: hdl/linear_array_deque.sv
// ----------------------------------------------------------------------------
// linear_array_deque
// Double-ended queue on a linear, non-wrapping store of DEPTH signed words.
// ----------------------------------------------------------------------------
// One item is handled at a time. An accepted item is captured, run against
// the slot memory in the EXEC state and loaded into the result register in
// the FETCH state; the result is then presented on the master side in the
// OUT state until it is taken. The next item is taken the cycle after the
// result is taken. The FETCH state is there because the slot memory's read
// data is registered before it reaches the result register. Inserts past the
// top or bottom slot return overflow, deletes from an empty queue return
// underflow with zero data.
module linear_array_deque #(
  parameter int DEPTH = lad_pkg::DefaultDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: op[1:0], data_in[33:2], zero pad.
  input  logic [lad_pkg::InTdataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: data_out[31:0], status[33:32], zero pad.
  output logic [lad_pkg::OutTdataW-1:0]    m_axis_tdata
);
  import lad_pkg::*;

  lad_cmd_t                cmd;
  logic signed [DataW-1:0] data_out;
  logic [StatW-1:0]        status;

  lad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  lad_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (s_axis_tdata[OpW-1:0]),
    .data_in_i  (s_axis_tdata[OpW+DataW-1:OpW]),
    .data_out_o (data_out),
    .status_o   (status)
  );

  assign m_axis_tdata = {{(OutTdataW - DataW - StatW){1'b0}}, status, data_out};

endmodule

FILE: hdl/lad_checker.sv
// ----------------------------------------------------------------------------
// lad_checker
// Port-level checks for the linear array deque, bound to the top level.
// ----------------------------------------------------------------------------
module lad_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [lad_pkg::InTdataW-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lad_pkg::OutTdataW-1:0] m_axis_tdata
);
  import lad_pkg::*;

  logic [StatW-1:0] stat;
  logic [DataW-1:0] dout;

  assign stat = m_axis_tdata[DataW+StatW-1:DataW];
  assign dout = m_axis_tdata[DataW-1:0];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("item accepted while a result is pending");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##2 m_axis_tvalid)
    else $error("result not presented in time");

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> stat == STAT_OK || stat == STAT_OVERFLOW || stat == STAT_UNDERFLOW)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && stat != STAT_OK |-> dout == '0)
    else $error("failed request returned data");

endmodule

bind linear_array_deque lad_checker u_lad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear array deque.
// ----------------------------------------------------------------------------
// A directed sequence walks the queue through both empty-queue cases, both
// overflow limits and the return to slot 0 on the last delete. Random bursts
// of inserts and deletes follow, with full-range data. Every accepted item is
// run through a local copy of the deque, and each result on the master side
// is compared with the oldest predicted removal. Both sides insert random
// wait cycles, with quiet stretches where they do not wait at all.
// ----------------------------------------------------------------------------
module tb;
  import lad_pkg::*;

  localparam int Depth       = DefaultDepth;
  localparam int IdxW        = $clog2(Depth);
  localparam int RandomItems = 2000;
  localparam int CycleLimit  = 400000;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] value;
  } request_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [StatW-1:0] status;
  } removal_t;

  typedef enum int {
    BurstInsRear, BurstInsFront, BurstInsMix,
    BurstDelFront, BurstDelRear, BurstDelMix, BurstAny
  } burst_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;

  request_t    request_q[$];
  removal_t    removal_q[$];
  logic        in_fire       = 1'b0;
  logic        out_fire      = 1'b0;
  int unsigned in_gap        = 0;
  int unsigned out_stall     = 0;
  int unsigned sent_count    = 0;
  int unsigned taken_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatch_count = 0;

  logic [DataW-1:0] mirror_slot[Depth];
  logic [IdxW-1:0]  mirror_front = '0;
  logic [IdxW-1:0]  mirror_rear  = '0;
  logic             mirror_empty = 1'b1;

  linear_array_deque #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait(int unsigned n);
    return ((n / 128) % 3 == 2) ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [DataW-1:0] extreme_value(int unsigned k);
    case (k)
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      4:       return 32'h5555_5555;
      5:       return 32'haaaa_aaaa;
      6:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DataW-1:0] random_value();
    return ($urandom_range(0, 7) == 0) ? extreme_value($urandom_range(0, 6)) : $urandom;
  endfunction

  function automatic logic [OpW-1:0] pick_op(burst_e kind);
    bit coin;
    bit coin2;
    coin  = 1'($urandom_range(0, 1));
    coin2 = 1'($urandom_range(0, 1));
    case (kind)
      BurstInsRear:  return OP_INS_REAR;
      BurstInsFront: return OP_INS_FRONT;
      BurstInsMix:   return coin ? OP_INS_FRONT : OP_INS_REAR;
      BurstDelFront: return OP_DEL_FRONT;
      BurstDelRear:  return OP_DEL_REAR;
      BurstDelMix:   return coin ? OP_DEL_REAR : OP_DEL_FRONT;
      default: begin
        if (coin) begin
          return coin2 ? OP_INS_FRONT : OP_INS_REAR;
        end else begin
          return coin2 ? OP_DEL_REAR : OP_DEL_FRONT;
        end
      end
    endcase
  endfunction

  task automatic push_request(input logic [OpW-1:0] op, input logic [DataW-1:0] value);
    request_t req;
    req.op    = op;
    req.value = value;
    request_q.push_back(req);
  endtask

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("mismatch in %s at %0t: got %08h, expected %08h", what, $time, got, want);
    mismatch_count++;
  endtask

  // Updates the local deque copy and returns what the block should report.
  task automatic apply_deque_op(input logic [OpW-1:0] op, input logic [DataW-1:0] value,
                                output logic [DataW-1:0] removed,
                                output logic [StatW-1:0] status);
    removed = '0;
    status  = STAT_OK;
    case (op)
      OP_INS_REAR, OP_INS_FRONT: begin
        if (mirror_empty) begin
          mirror_slot[0] = value;
          mirror_front   = '0;
          mirror_rear    = '0;
          mirror_empty   = 1'b0;
        end else if (op == OP_INS_REAR) begin
          if (mirror_rear == IdxW'(Depth - 1)) begin
            status = STAT_OVERFLOW;
          end else begin
            mirror_rear              = mirror_rear + 1'b1;
            mirror_slot[mirror_rear] = value;
          end
        end else if (mirror_front == '0) begin
          status = STAT_OVERFLOW;
        end else begin
          mirror_front              = mirror_front - 1'b1;
          mirror_slot[mirror_front] = value;
        end
      end
      default: begin
        if (mirror_empty) begin
          status = STAT_UNDERFLOW;
        end else begin
          removed = (op == OP_DEL_FRONT) ? mirror_slot[mirror_front] : mirror_slot[mirror_rear];
          if (mirror_front == mirror_rear) begin
            mirror_front = '0;
            mirror_rear  = '0;
            mirror_empty = 1'b1;
          end else if (op == OP_DEL_FRONT) begin
            mirror_front = mirror_front + 1'b1;
          end else begin
            mirror_rear = mirror_rear - 1'b1;
          end
        end
      end
    endcase
  endtask

  always @(negedge clk_i or negedge rst_ni) begin : driver
    request_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (in_gap != 0) begin
        in_gap        <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() != 0) begin
        req           = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InTdataW - DataW - OpW){1'b0}}, req.value, req.op};
        in_gap        <= draw_wait(sent_count);
        sent_count    <= sent_count + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin : sink
    int unsigned stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_stall     <= 0;
    end else if (out_fire) begin
      stall         = draw_wait(taken_count);
      m_axis_tready <= (stall == 0);
      out_stall     <= stall;
    end else if (out_stall != 0) begin
      m_axis_tready <= (out_stall == 1);
      out_stall     <= out_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    removal_t         want;
    logic [DataW-1:0] removed;
    logic [StatW-1:0] status;
    if (rst_ni) begin
      in_fire  <= s_axis_tvalid && s_axis_tready;
      out_fire <= m_axis_tvalid && m_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_deque_op(s_axis_tdata[OpW-1:0], s_axis_tdata[OpW +: DataW], removed, status);
        want.value  = removed;
        want.status = status;
        removal_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        taken_count <= taken_count + 1;
        if (removal_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[DataW-1:0], '0);
        end else begin
          want = removal_q.pop_front();
          if (m_axis_tdata[DataW-1:0] !== want.value) begin
            report_mismatch("data_out", m_axis_tdata[DataW-1:0], want.value);
          end
          if (m_axis_tdata[DataW +: StatW] !== want.status) begin
            report_mismatch("status", DataW'(m_axis_tdata[DataW +: StatW]), DataW'(want.status));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[linear_array_deque] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned random_count;
    int unsigned burst_len;
    burst_e      kind;

    push_request(OP_DEL_FRONT, $urandom);
    push_request(OP_DEL_REAR, $urandom);
    push_request(OP_INS_FRONT, 32'h8000_0000);
    push_request(OP_DEL_REAR, $urandom);
    for (int k = 0; k < Depth; k++) begin
      push_request(OP_INS_REAR, extreme_value(k));
    end
    push_request(OP_INS_REAR, 32'h1234_5678);
    push_request(OP_DEL_FRONT, $urandom);
    push_request(OP_DEL_FRONT, $urandom);
    push_request(OP_INS_FRONT, 32'h7fff_ffff);
    push_request(OP_INS_FRONT, 32'h8000_0000);
    push_request(OP_INS_FRONT, 32'hffff_ffff);
    for (int k = 0; k < Depth; k++) begin
      push_request((k % 2 == 0) ? OP_DEL_REAR : OP_DEL_FRONT, $urandom);
    end
    push_request(OP_DEL_FRONT, $urandom);

    random_count = 0;
    while (random_count < RandomItems) begin
      kind      = burst_e'($urandom_range(0, 6));
      burst_len = $urandom_range(1, 10);
      for (int k = 0; k < burst_len; k++) begin
        push_request(pick_op(kind), random_value());
        random_count++;
      end
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (removal_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[linear_array_deque] OK");
    end else begin
      $display("[linear_array_deque] ERROR");
    end
    $finish;
  end

endmodule
